[hdl/lsh_pkg.sv]
// shared types, constants and functions of the lookup2 string hash core
// no dependencies; imported by every other file of the block
package lsh_pkg;

    localparam int WORD_W      = 32;
    localparam int BYTE_W      = 8;
    localparam int BLOCK_BYTES = 12;
    localparam int FILL_W      = 4;
    localparam int MIX_STEPS   = 9;
    localparam int STEP_W      = 4;
    localparam int SHIFT_W     = 5;

    localparam logic [WORD_W-1:0] GOLDEN_RATIO = 32'h9e37_79b9;

    // one unit of work handed from the front to the back
    typedef struct packed {
        logic              start;   // first job of a key: load the start values
        logic              full;    // words hold a whole block
        logic              close;   // key ends with this job
        logic [WORD_W-1:0] seed;
        logic [WORD_W-1:0] word_a;
        logic [WORD_W-1:0] word_b;
        logic [WORD_W-1:0] word_c;
        logic [WORD_W-1:0] len;
    } lsh_job_t;

    // shift amount of each line of the mix
    function automatic logic [SHIFT_W-1:0] mix_shift(input logic [STEP_W-1:0] step);
        logic [SHIFT_W-1:0] sh;
        unique case (step)
            4'd0:    sh = 5'd13;
            4'd1:    sh = 5'd8;
            4'd2:    sh = 5'd13;
            4'd3:    sh = 5'd12;
            4'd4:    sh = 5'd16;
            4'd5:    sh = 5'd5;
            4'd6:    sh = 5'd3;
            4'd7:    sh = 5'd10;
            4'd8:    sh = 5'd15;
            default: sh = 5'd0;
        endcase
        return sh;
    endfunction

endpackage

[hdl/lsh_if.sv]
// channel interfaces of the lookup2 string hash core: key bytes, hash, config
// depends on lsh_pkg
interface lsh_byte_if;
    import lsh_pkg::*;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;
    logic              byte_valid;
    logic              last;
    modport source (output valid, data_byte, byte_valid, last, input ready);
    modport sink   (input valid, data_byte, byte_valid, last, output ready);
endinterface

interface lsh_hash_if;
    import lsh_pkg::*;
    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] hash_value;
    modport source (output valid, hash_value, input ready);
    modport sink   (input valid, hash_value, output ready);
endinterface

interface lsh_cfg_if;
    import lsh_pkg::*;
    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] data;
    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

[hdl/lookup2_string_hash_core.sv]
// top level of the lookup2 string hash core: seed register, front, queue, back
// depends on lsh_pkg, lsh_if, lsh_front, lsh_queue, lsh_back
//
// channel    dir  payload                          moves on
// key_in     in   data_byte, byte_valid, last      valid && ready
// hash_out   out  hash_value                       valid && ready
// cfg        in   data (init_value)                valid && ready
//
// key bytes are taken one per cycle while the job queue has room; the back runs
// the one-line-per-cycle mix unit once per 12-byte block and once more to close a
// key that ends exactly on a block, so a request stalls only when the
// job queue is full. reset returns to no key open, seed 0, output empty.
// the hash waits in an output register and does not block the next key's bytes.
module lookup2_string_hash_core #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic       clk,
    input  logic       rst_n,
    lsh_byte_if.sink   key_in,
    lsh_hash_if.source hash_out,
    lsh_cfg_if.sink    cfg
);
    import lsh_pkg::*;

    logic [WORD_W-1:0] init_value_reg;
    lsh_job_t          front_job;
    lsh_job_t          back_job;
    logic              front_push;
    logic              queue_ready;
    logic              back_valid;
    logic              back_pop;

    // seed register
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            init_value_reg <= '0;
        else if (cfg.valid && cfg.ready)
            init_value_reg <= cfg.data;
    end

    lsh_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .key_in    (key_in),
        .seed      (init_value_reg),
        .job       (front_job),
        .job_push  (front_push),
        .job_ready (queue_ready)
    );

    lsh_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_job    (front_job),
        .in_push   (front_push),
        .in_ready  (queue_ready),
        .out_job   (back_job),
        .out_valid (back_valid),
        .out_pop   (back_pop)
    );

    lsh_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job       (back_job),
        .job_valid (back_valid),
        .job_pop   (back_pop),
        .hash_out  (hash_out)
    );

endmodule

[hdl/lsh_front.sv]
// front end: takes key bytes, gathers 12-byte blocks, counts length, builds jobs
// depends on lsh_pkg and lsh_byte_if
module lsh_front (
    input  logic                       clk,
    input  logic                       rst_n,
    lsh_byte_if.sink                   key_in,
    input  logic [lsh_pkg::WORD_W-1:0] seed,
    output lsh_pkg::lsh_job_t          job,
    output logic                       job_push,
    input  logic                       job_ready
);
    import lsh_pkg::*;

    logic [BYTE_W-1:0] block_reg [BLOCK_BYTES];
    logic [FILL_W-1:0] fill_reg;
    logic [FILL_W-1:0] fill_next;
    logic [WORD_W-1:0] count_reg;
    logic [WORD_W-1:0] count_next;
    logic              started_reg;
    logic              started_next;
    logic              open_reg;
    logic              open_next;
    logic [WORD_W-1:0] seed_hold_reg;
    logic [WORD_W-1:0] seed_hold_next;

    logic              accept;
    logic              take_byte;
    logic              full;
    logic              close;
    logic [FILL_W-1:0] new_fill;
    logic [WORD_W-1:0] len;
    logic [WORD_W-1:0] key_seed;
    logic [BYTE_W-1:0] lane [BLOCK_BYTES];

    assign key_in.ready = job_ready;
    assign accept       = key_in.valid && key_in.ready;
    assign take_byte    = accept && key_in.byte_valid;
    assign close        = accept && key_in.last;
    assign full         = take_byte && (fill_reg == FILL_W'(BLOCK_BYTES - 1));
    assign new_fill     = fill_reg + FILL_W'(key_in.byte_valid);
    assign len          = count_reg + WORD_W'(key_in.byte_valid);
    assign job_push     = full || close;

    // seed as sampled on the first request of the key
    assign key_seed     = open_reg ? seed_hold_reg : seed;

    // block bytes with the incoming byte merged in, unwritten lanes zeroed
    always_comb
    begin
        for (int i = 0; i < BLOCK_BYTES; i++)
        begin
            if (key_in.byte_valid && (fill_reg == FILL_W'(i)))
                lane[i] = key_in.data_byte;
            else if (FILL_W'(i) < new_fill)
                lane[i] = block_reg[i];
            else
                lane[i] = '0;
        end
    end

    // job words: tail bytes 8..10 sit one byte up in c, with the length added
    always_comb
    begin
        job.start  = !started_reg;
        job.full   = full;
        job.close  = close;
        job.seed   = key_seed;
        job.word_a = {lane[3], lane[2], lane[1], lane[0]};
        job.word_b = {lane[7], lane[6], lane[5], lane[4]};
        job.len    = len;
        if (full)
            job.word_c = {lane[11], lane[10], lane[9], lane[8]};
        else
            job.word_c = {lane[10], lane[9], lane[8], {BYTE_W{1'b0}}} + len;
    end

    // key progress
    always_comb
    begin
        fill_next      = fill_reg;
        count_next     = count_reg;
        started_next   = started_reg;
        open_next      = open_reg;
        seed_hold_next = seed_hold_reg;
        if (close)
        begin
            fill_next    = '0;
            count_next   = '0;
            started_next = 1'b0;
            open_next    = 1'b0;
        end
        else if (take_byte)
        begin
            fill_next      = full ? '0 : new_fill;
            count_next     = len;
            started_next   = started_reg || full;
            open_next      = 1'b1;
            seed_hold_next = key_seed;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            count_reg     <= '0;
            started_reg   <= 1'b0;
            open_reg      <= 1'b0;
            seed_hold_reg <= '0;
        end
        else
        begin
            fill_reg      <= fill_next;
            count_reg     <= count_next;
            started_reg   <= started_next;
            open_reg      <= open_next;
            seed_hold_reg <= seed_hold_next;
        end
    end

    // byte lanes, written at the fill position
    always_ff @(posedge clk)
    begin
        if (take_byte)
            block_reg[fill_reg] <= key_in.data_byte;
    end

endmodule

[hdl/lsh_queue.sv]
// short job queue between the front and the back of the hash core
// depends on lsh_pkg
module lsh_queue #(
    parameter int DEPTH = 2
) (
    input  logic              clk,
    input  logic              rst_n,
    input  lsh_pkg::lsh_job_t in_job,
    input  logic              in_push,
    output logic              in_ready,
    output lsh_pkg::lsh_job_t out_job,
    output logic              out_valid,
    input  logic              out_pop
);
    import lsh_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    lsh_job_t         slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign in_ready  = (count_reg != CNT_W'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_job   = slot_reg[rd_ptr_reg];
    assign do_push   = in_push && in_ready;
    assign do_pop    = out_pop && out_valid;

    // pointer wrap and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        count_next = count_reg + CNT_W'(do_push) - CNT_W'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= in_job;
    end

endmodule

[hdl/lsh_back.sv]
// back end: adds job words into a, b, c and runs the mix one line per cycle
// depends on lsh_pkg and lsh_hash_if
module lsh_back (
    input  logic              clk,
    input  logic              rst_n,
    input  lsh_pkg::lsh_job_t job,
    input  logic              job_valid,
    output logic              job_pop,
    lsh_hash_if.source        hash_out
);
    import lsh_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_ADD  = 4'b0010,
        ST_MIX  = 4'b0100,
        ST_FIN  = 4'b1000
    } back_state_t;

    typedef enum logic [1:0] {
        ROLE_A,
        ROLE_B,
        ROLE_C
    } mix_role_t;

    back_state_t       state_reg;
    back_state_t       state_next;
    mix_role_t         role_reg;
    mix_role_t         role_next;
    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    logic              second_reg;
    logic              second_next;
    lsh_job_t          job_reg;
    logic [WORD_W-1:0] acc_a_reg;
    logic [WORD_W-1:0] acc_b_reg;
    logic [WORD_W-1:0] acc_c_reg;
    logic [WORD_W-1:0] acc_a_next;
    logic [WORD_W-1:0] acc_b_next;
    logic [WORD_W-1:0] acc_c_next;
    logic [WORD_W-1:0] hash_reg;
    logic              out_valid_reg;
    logic              out_valid_next;

    logic [WORD_W-1:0] base_a;
    logic [WORD_W-1:0] base_b;
    logic [WORD_W-1:0] base_c;
    logic [WORD_W-1:0] add_a;
    logic [WORD_W-1:0] add_b;
    logic [WORD_W-1:0] add_c;
    logic [SHIFT_W-1:0] sh;
    logic              emit;
    logic              last_step;

    assign job_pop             = (state_reg == ST_IDLE) && job_valid;
    assign hash_out.valid      = out_valid_reg;
    assign hash_out.hash_value = hash_reg;
    assign sh                  = mix_shift(step_reg);
    assign last_step           = (step_reg == STEP_W'(MIX_STEPS - 1));
    assign emit = (state_reg == ST_FIN) && (!out_valid_reg || hash_out.ready);

    // start values on the first pass of a key, words or length per pass
    always_comb
    begin
        if (job_reg.start && !second_reg)
        begin
            base_a = GOLDEN_RATIO;
            base_b = GOLDEN_RATIO;
            base_c = job_reg.seed;
        end
        else
        begin
            base_a = acc_a_reg;
            base_b = acc_b_reg;
            base_c = acc_c_reg;
        end
        if (second_reg)
        begin
            add_a = '0;
            add_b = '0;
            add_c = job_reg.len;
        end
        else
        begin
            add_a = job_reg.word_a;
            add_b = job_reg.word_b;
            add_c = job_reg.word_c;
        end
    end

    // sequencer and one mix line per cycle
    always_comb
    begin
        state_next  = state_reg;
        role_next   = role_reg;
        step_next   = step_reg;
        second_next = second_reg;
        acc_a_next  = acc_a_reg;
        acc_b_next  = acc_b_reg;
        acc_c_next  = acc_c_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                second_next = 1'b0;
                if (job_valid)
                    state_next = ST_ADD;
            end
            ST_ADD:
            begin
                acc_a_next = base_a + add_a;
                acc_b_next = base_b + add_b;
                acc_c_next = base_c + add_c;
                step_next  = '0;
                role_next  = ROLE_A;
                state_next = ST_MIX;
            end
            ST_MIX:
            begin
                unique case (role_reg)
                    ROLE_A:
                    begin
                        acc_a_next = (acc_a_reg - acc_b_reg - acc_c_reg) ^ (acc_c_reg >> sh);
                        role_next  = ROLE_B;
                    end
                    ROLE_B:
                    begin
                        acc_b_next = (acc_b_reg - acc_c_reg - acc_a_reg) ^ (acc_a_reg << sh);
                        role_next  = ROLE_C;
                    end
                    ROLE_C:
                    begin
                        acc_c_next = (acc_c_reg - acc_a_reg - acc_b_reg) ^ (acc_b_reg >> sh);
                        role_next  = ROLE_A;
                    end
                    default:
                    begin
                        role_next = ROLE_A;
                    end
                endcase
                step_next = step_reg + 1'b1;
                if (last_step)
                begin
                    if (job_reg.close && job_reg.full && !second_reg)
                    begin
                        second_next = 1'b1;
                        state_next  = ST_ADD;
                    end
                    else if (job_reg.close)
                        state_next = ST_FIN;
                    else
                        state_next = ST_IDLE;
                end
            end
            ST_FIN:
            begin
                if (emit)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit)
            out_valid_next = 1'b1;
        else if (hash_out.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            second_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            second_reg    <= second_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        role_reg  <= role_next;
        step_reg  <= step_next;
        acc_a_reg <= acc_a_next;
        acc_b_reg <= acc_b_next;
        acc_c_reg <= acc_c_next;
        if (job_pop)
            job_reg <= job;
        if (emit)
            hash_reg <= acc_c_reg;
    end

endmodule
